// File: design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// Ring fault diagnosis package
// Shared types, codes and helper functions for the ring diagnosis table.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int MAX_NODES   = 8;
  localparam int NODE_W      = 3;
  localparam int COUNT_W     = 4;
  localparam int KIND_W      = 2;
  localparam int ENTRY_W     = 2;
  localparam int VEC_W       = MAX_NODES * ENTRY_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [KIND_W-1:0] KIND_TEST     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAULT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECOVERY = 2'd2;

  localparam logic [ENTRY_W-1:0] ENTRY_NORMAL  = 2'd0;
  localparam logic [ENTRY_W-1:0] ENTRY_FAULTY  = 2'd1;
  localparam logic [ENTRY_W-1:0] ENTRY_UNKNOWN = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = 4'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  typedef logic [MAX_NODES-1:0][ENTRY_W-1:0] row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] tester;
    logic [VEC_W-1:0]  diag_vector;
    logic              found_healthy;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_TEST    = 2'd0,
    OP_FAULT   = 2'd1,
    OP_RECOVER = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [NODE_W-1:0] node;
  } cmd_t;

  function automatic logic [COUNT_W-1:0] active_count(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] n;
    begin
      n = cnt;
      if (cnt < COUNT_MIN) n = COUNT_MIN;
      if (cnt > COUNT_MAX) n = COUNT_MAX;
      return n;
    end
  endfunction

  function automatic row_t reset_row(input logic [NODE_W-1:0] idx);
    row_t row;
    begin
      for (int k = 0; k < MAX_NODES; k++) begin
        row[k] = (k[NODE_W-1:0] == idx) ? ENTRY_NORMAL : ENTRY_UNKNOWN;
      end
      return row;
    end
  endfunction

  function automatic logic [NODE_W-1:0] next_node(input logic [NODE_W-1:0] x,
                                                  input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] inc;
    begin
      inc = {1'b0, x} + 4'd1;
      return (inc == n) ? '0 : inc[NODE_W-1:0];
    end
  endfunction

endpackage

// File: design/rfd_front.sv
// ----------------------------------------------------------------------------
// Ring diagnosis front end
// Accepts events, drops those outside the ring or of an unused kind, and
// turns the rest into commands for the queue.
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rfd_pkg::in_item_t            in_data,
  input  logic [rfd_pkg::COUNT_W-1:0]  node_count,
  output logic                         push,
  output rfd_pkg::cmd_t                push_cmd,
  input  logic                         full
);

  logic [rfd_pkg::COUNT_W-1:0] n_eff;
  logic                        in_range;
  logic                        known_kind;
  logic                        accepted;

  assign n_eff      = rfd_pkg::active_count(node_count);
  assign in_range   = {1'b0, in_data.node} < n_eff;
  assign known_kind = (in_data.kind == rfd_pkg::KIND_TEST) ||
                      (in_data.kind == rfd_pkg::KIND_FAULT) ||
                      (in_data.kind == rfd_pkg::KIND_RECOVERY);
  assign in_stall   = full;
  assign accepted   = in_valid && !full;
  assign push       = accepted && in_range && known_kind;

  always_comb begin
    push_cmd.node = in_data.node;
    case (in_data.kind)
      rfd_pkg::KIND_FAULT:    push_cmd.op = rfd_pkg::OP_FAULT;
      rfd_pkg::KIND_RECOVERY: push_cmd.op = rfd_pkg::OP_RECOVER;
      default:                push_cmd.op = rfd_pkg::OP_TEST;
    endcase
  end

endmodule

// File: design/rfd_queue.sv
// ----------------------------------------------------------------------------
// Ring diagnosis command queue
// Short FIFO that decouples event intake from command execution.
// ----------------------------------------------------------------------------
module rfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfd_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output rfd_pkg::cmd_t pop_cmd
);

  rfd_pkg::cmd_t               slots [rfd_pkg::QUEUE_DEPTH];
  logic [rfd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rfd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rfd_pkg::QCNT_W-1:0]  count;
  logic                        do_pop;

  assign full      = count == rfd_pkg::QCNT_W'(rfd_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/rfd_back.sv
// ----------------------------------------------------------------------------
// Ring diagnosis back end
// Executes queued commands: keeps the failed flags and the diagnosis rows,
// walks the successors of a tester and delivers its vector.
// ----------------------------------------------------------------------------
module rfd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  input  rfd_pkg::cmd_t                cmd,
  input  logic [rfd_pkg::COUNT_W-1:0]  node_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rfd_pkg::out_item_t           out_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_WALK  = 5'b00100,
    S_COPY  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t                             state;
  logic [rfd_pkg::MAX_NODES-1:0]      failed;
  logic [rfd_pkg::MAX_NODES-1:0]      row_valid;
  rfd_pkg::row_t                      mem [rfd_pkg::MAX_NODES];
  rfd_pkg::row_t                      rd_row;
  logic                               rd_row_valid;
  logic [rfd_pkg::NODE_W-1:0]         rd_row_idx;
  logic                               rd_en;
  logic [rfd_pkg::NODE_W-1:0]         rd_addr;
  rfd_pkg::row_t                      eff_row;
  rfd_pkg::row_t                      work;
  rfd_pkg::row_t                      copy_row;
  rfd_pkg::row_t                      shown_row;
  logic [rfd_pkg::NODE_W-1:0]         tester;
  logic [rfd_pkg::NODE_W-1:0]         succ;
  logic [rfd_pkg::NODE_W-1:0]         step;
  logic                               found;
  logic [rfd_pkg::COUNT_W-1:0]        n_eff;
  logic                               out_free;
  logic                               walk_last;

  assign n_eff     = rfd_pkg::active_count(node_count);
  assign out_free  = !out_valid || !out_stall;
  assign cmd_pop   = state == S_IDLE;
  assign walk_last = {1'b0, step} == (n_eff - 4'd1);
  assign eff_row   = rd_row_valid ? rd_row : rfd_pkg::reset_row(rd_row_idx);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmd.node;
    case (state)
      S_IDLE: begin
        rd_en   = cmd_valid && (cmd.op == rfd_pkg::OP_TEST) && !failed[cmd.node];
        rd_addr = cmd.node;
      end
      S_WALK: begin
        rd_en   = !failed[succ];
        rd_addr = succ;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = cmd.node;
      end
    endcase
  end

  // Entries strictly beyond the found successor, in ring order from the tester.
  always_comb begin
    logic [rfd_pkg::COUNT_W-1:0] ring_ofs;
    for (int k = 0; k < rfd_pkg::MAX_NODES; k++) begin
      if (k[rfd_pkg::NODE_W-1:0] >= tester) begin
        ring_ofs = rfd_pkg::COUNT_W'(k) - {1'b0, tester};
      end else begin
        ring_ofs = rfd_pkg::COUNT_W'(k) + n_eff - {1'b0, tester};
      end
      if ((rfd_pkg::COUNT_W'(k) < n_eff) && (ring_ofs > {1'b0, step})) begin
        copy_row[k] = eff_row[k];
      end else begin
        copy_row[k] = work[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < rfd_pkg::MAX_NODES; k++) begin
      shown_row[k] = (rfd_pkg::COUNT_W'(k) < n_eff) ? work[k] : rfd_pkg::ENTRY_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row       <= mem[rd_addr];
      rd_row_valid <= row_valid[rd_addr];
      rd_row_idx   <= rd_addr;
    end
    if (state == S_WRITE && out_free) begin
      mem[tester] <= work;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tester <= cmd.node;
      end
      S_LOAD: begin
        work <= eff_row;
        step <= rfd_pkg::NODE_W'(1);
        succ <= rfd_pkg::next_node(tester, n_eff);
      end
      S_WALK: begin
        if (failed[succ]) begin
          work[succ] <= rfd_pkg::ENTRY_FAULTY;
          found      <= 1'b0;
          step       <= step + 1'b1;
          succ       <= rfd_pkg::next_node(succ, n_eff);
        end else begin
          work[succ] <= rfd_pkg::ENTRY_NORMAL;
        end
      end
      S_COPY: begin
        work  <= copy_row;
        found <= 1'b1;
      end
      default: begin
      end
    endcase
    if (state == S_WRITE && out_free) begin
      out_data.tester        <= tester;
      out_data.diag_vector   <= shown_row;
      out_data.found_healthy <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      failed    <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_WRITE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              rfd_pkg::OP_FAULT:   failed[cmd.node] <= 1'b1;
              rfd_pkg::OP_RECOVER: failed[cmd.node] <= 1'b0;
              default: begin
                if (!failed[cmd.node]) state <= S_LOAD;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (!failed[succ]) begin
            state <= S_COPY;
          end else if (walk_last) begin
            state <= S_WRITE;
          end
        end
        S_COPY: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            row_valid[tester] <= 1'b1;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/ring_fault_diagnosis_table_top.sv
// ----------------------------------------------------------------------------
// Ring fault diagnosis table
// A front end classifies events into a four-entry command queue; a back end
// executes them one at a time. Fault and recovery events, and a test by a
// failed node, are handled without leaving the idle state. A test by a
// healthy node reads the tester's row in the idle state, loads it, examines
// the successors in ring order up to and including the first healthy one
// (whose row is read as it is examined), merges that row, and then writes
// the row back and loads the output register. When every successor has
// failed there is no merge step. A stalled output holds the back end in its
// write state. The walk over successors sets the rate. Events dropped as
// out of range or of an unused kind cost nothing in the back end. The node
// count register takes effect at once and should be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module ring_fault_diagnosis_table_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rfd_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rfd_pkg::out_item_t           out_data,
  input  logic                         cfg_write,
  input  logic [rfd_pkg::COUNT_W-1:0]  cfg_data
);

  logic [rfd_pkg::COUNT_W-1:0] node_count;
  logic                        push;
  rfd_pkg::cmd_t               push_cmd;
  logic                        full;
  logic                        cmd_valid;
  logic                        cmd_pop;
  rfd_pkg::cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= rfd_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      node_count <= cfg_data;
    end
  end

  rfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .node_count (node_count),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full)
  );

  rfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop_valid (cmd_valid),
    .pop       (cmd_pop),
    .pop_cmd   (cmd)
  );

  rfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .node_count (node_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: sim/diag_report_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Diagnosis report checker
// Watches the event, report and node count ports of the ring diagnosis
// table. It keeps its own failed flags and diagnosis rows and predicts the
// report of every accepted test by a healthy node. Each accepted report is
// compared field by field with the oldest prediction; each failure counts.
// ----------------------------------------------------------------------------
module diag_report_checker
  import rfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_data,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);

  logic [COUNT_W-1:0] ring_size;
  logic               node_down [MAX_NODES];
  row_t               diag_row  [MAX_NODES];
  out_item_t          report_q  [$];
  int                 failures = 0;

  assign fail_count = failures;

  task automatic clear_tables();
    for (int a = 0; a < MAX_NODES; a++) begin
      node_down[a] = 1'b0;
      for (int b = 0; b < MAX_NODES; b++) begin
        diag_row[a][b] = (a == b) ? ENTRY_NORMAL : ENTRY_UNKNOWN;
      end
    end
    ring_size = COUNT_RESET;
  endtask

  task automatic apply_event(input in_item_t ev);
    int        n;
    int        nd;
    int        s;
    int        f;
    logic      found;
    out_item_t rep;
    n = int'(ring_size);
    if (ring_size < COUNT_MIN) n = int'(COUNT_MIN);
    if (ring_size > COUNT_MAX) n = int'(COUNT_MAX);
    nd = int'(ev.node);
    if (nd < n) begin
      case (ev.kind)
        KIND_FAULT: begin
          node_down[nd] = 1'b1;
        end
        KIND_RECOVERY: begin
          node_down[nd] = 1'b0;
        end
        KIND_TEST: begin
          if (!node_down[nd]) begin
            found = 1'b0;
            for (int i = 1; i < n; i++) begin
              if (!found) begin
                s = (nd + i) % n;
                if (!node_down[s]) begin
                  diag_row[nd][s] = ENTRY_NORMAL;
                  for (int j = i + 1; j < n; j++) begin
                    f = (nd + j) % n;
                    diag_row[nd][f] = diag_row[s][f];
                  end
                  found = 1'b1;
                end else begin
                  diag_row[nd][s] = ENTRY_FAULTY;
                end
              end
            end
            rep.tester        = ev.node;
            rep.diag_vector   = '0;
            rep.found_healthy = found;
            for (int k = 0; k < n; k++) begin
              rep.diag_vector[2*k +: 2] = diag_row[nd][k];
            end
            report_q.push_back(rep);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (report_q.size() == 0) begin
      $error("unexpected report: tester %0d, diag_vector %04h, found_healthy %0b",
             got.tester, got.diag_vector, got.found_healthy);
      failures++;
    end else begin
      want = report_q.pop_front();
      if (got.tester !== want.tester) begin
        $error("tester: expected %0d, actual %0d", want.tester, got.tester);
        failures++;
      end
      if (got.diag_vector !== want.diag_vector) begin
        $error("diag_vector: expected %04h, actual %04h", want.diag_vector, got.diag_vector);
        failures++;
      end
      if (got.found_healthy !== want.found_healthy) begin
        $error("found_healthy: expected %0b, actual %0b", want.found_healthy,
               got.found_healthy);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      report_q.delete();
      pending <= 0;
    end else begin
      if (cfg_write) ring_size = cfg_data;
      if (out_valid && !out_stall) check_report(out_data);
      if (in_valid && !in_stall) apply_event(in_data);
      pending <= report_q.size();
    end
  end

endmodule

// File: sim/tb_ring_fault_diagnosis_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ring fault diagnosis table testbench
// Drives directed and random fault, recovery, test and unused-kind events
// through the ring diagnosis table under several node counts, with random
// idle bursts on both channels. A separate checker predicts and compares
// the reports; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ring_fault_diagnosis_table_top;
  import rfd_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_write = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  ring_fault_diagnosis_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  diag_report_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] nd);
    in_item_t ev;
    ev.kind  = k;
    ev.node  = nd;
    in_data  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // The last report can arrive while fault and recovery events are still
  // queued, so the settle time covers a full command queue.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [COUNT_W-1:0] count_plan [NUM_PHASES];
    logic [KIND_W-1:0]  k;
    logic [NODE_W-1:0]  nd;
    int                 eff;
    int                 counted;
    int                 r;
    bit                 paused;

    count_plan = '{4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd7, 4'd9, 4'd4, 4'd6,
                   4'd8};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 30;
    stall_pct = 30;
    write_count(COUNT_MAX);
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_FAULT, 3'd1);
    send_event(KIND_FAULT, 3'd2);
    send_event(KIND_FAULT, 3'd1);
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_TEST, 3'd1);
    for (int i = 3; i < MAX_NODES; i++) begin
      send_event(KIND_FAULT, i[NODE_W-1:0]);
    end
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_RECOVERY, 3'd1);
    send_event(KIND_RECOVERY, 3'd1);
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_UNUSED, 3'd0);

    write_count(COUNT_MIN);
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_FAULT, 3'd1);
    send_event(KIND_TEST, 3'd0);
    send_event(KIND_TEST, 3'd5);
    send_event(KIND_RECOVERY, 3'd1);
    send_event(KIND_TEST, 3'd1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_count(count_plan[p]);
      quiet = (p == NUM_PHASES - 1);
      gap_pct   = quiet ? 0 : 25 * $urandom_range(0, 2);
      stall_pct = quiet ? 0 : 25 * $urandom_range(0, 2);
      eff = int'(count_plan[p]);
      if (count_plan[p] < COUNT_MIN) eff = int'(COUNT_MIN);
      if (count_plan[p] > COUNT_MAX) eff = int'(COUNT_MAX);
      counted = 0;
      paused  = 1'b0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 50) k = KIND_TEST;
        else if (r < 70) k = KIND_FAULT;
        else if (r < 94) k = KIND_RECOVERY;
        else k = KIND_UNUSED;
        if ($urandom_range(0, 99) < 90) nd = NODE_W'($urandom_range(0, eff - 1));
        else nd = NODE_W'($urandom_range(0, MAX_NODES - 1));
        if (k != KIND_UNUSED && int'(nd) < eff) counted++;
        send_event(k, nd);
        if (p == 2 && !paused && counted == ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_idle();
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
